// ----- rtl/core/c2s_pkg.sv -----
// Types and constants shared by the cartesian-to-spherical converter.
// Holds fixed coordinate and angle widths, the CORDIC arctangent table and the sideband type.
// No dependencies.
package c2s_pkg;

    localparam int COORD_BITS  = 16;
    localparam int ANGLE_BITS  = 16;
    localparam int FRAC_BITS   = 16;
    localparam int SQ_BITS     = 2 * COORD_BITS;
    localparam int RXY_BITS    = SQ_BITS;
    localparam int XR_REM_W    = RXY_BITS + 4;
    localparam int RADIUS_BITS = COORD_BITS + 2;
    localparam int RD_REM_W    = RADIUS_BITS + 4;
    localparam int RD_PAD      = 2;
    localparam int CORDIC_W    = 36;
    localparam int TURN_BITS   = 32;

    localparam logic [TURN_BITS-1:0] ANGLE_HALF =
        TURN_BITS'(1) << (TURN_BITS - ANGLE_BITS - 1);
    localparam logic [TURN_BITS-1:0] QUARTER_TURN       = 32'h4000_0000;
    localparam logic [TURN_BITS-1:0] THREE_QUARTER_TURN = 32'hC000_0000;
    localparam logic [ANGLE_BITS-1:0] PI_ANGLE = ANGLE_BITS'(1) << (ANGLE_BITS - 1);
    localparam logic [RADIUS_BITS-1:0] RADIUS_MAX = '1;

    // atan(2^-i) in units of 2^-32 turn
    localparam logic [TURN_BITS-1:0] ATAN_TAB [0:31] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
        32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
        32'd20861,     32'd10431,     32'd5215,      32'd2608,     32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
        32'd20,        32'd10,        32'd5,         32'd3,        32'd1,
        32'd1,         32'd0
    };

    typedef logic [TURN_BITS-1:0]       angle_t;
    typedef logic signed [CORDIC_W-1:0] cvec_t;

    typedef struct packed {
        logic [RADIUS_BITS-1:0] radius;
        logic                   axis;
        logic                   zneg;
    } side_t;

endpackage

// ----- rtl/core/c2s_cordic.sv -----
// Pipelined vectoring CORDIC: angle of (x, y) in units of 2^-32 turn.
// One register for the quadrant pre-rotation, then one register per iteration.
// Depends on c2s_pkg.
module c2s_cordic #(
    parameter int STAGES = 16
) (
    input  logic           aclk,
    input  logic           en,
    input  c2s_pkg::cvec_t x_in,
    input  c2s_pkg::cvec_t y_in,
    output c2s_pkg::angle_t ang_out
);
    import c2s_pkg::*;

    cvec_t  x_reg   [0:STAGES];
    cvec_t  y_reg   [0:STAGES];
    angle_t ang_reg [0:STAGES];

    cvec_t  x_next;
    cvec_t  y_next;
    angle_t ang_next;

    // fold the left half-plane into the right one
    always_comb begin
        x_next   = x_in;
        y_next   = y_in;
        ang_next = '0;
        if (x_in < 0) begin
            if (y_in >= 0) begin
                x_next   = y_in;
                y_next   = -x_in;
                ang_next = QUARTER_TURN;
            end else begin
                x_next   = -y_in;
                y_next   = x_in;
                ang_next = THREE_QUARTER_TURN;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]   <= x_next;
            y_reg[0]   <= y_next;
            ang_reg[0] <= ang_next;
        end
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_iter
        cvec_t dx;
        cvec_t dy;
        logic  pos;
        assign dx  = y_reg[i] >>> i;
        assign dy  = x_reg[i] >>> i;
        assign pos = y_reg[i] > 0;

        always_ff @(posedge aclk) begin
            if (en) begin
                if (pos) begin
                    x_reg[i+1]   <= x_reg[i] + dx;
                    y_reg[i+1]   <= y_reg[i] - dy;
                    ang_reg[i+1] <= ang_reg[i] + ATAN_TAB[i];
                end else begin
                    x_reg[i+1]   <= x_reg[i] - dx;
                    y_reg[i+1]   <= y_reg[i] + dy;
                    ang_reg[i+1] <= ang_reg[i] - ATAN_TAB[i];
                end
            end
        end
    end

    assign ang_out = ang_reg[STAGES];

endmodule

// ----- rtl/core/cartesian_to_spherical.sv -----
// Top level of the cartesian-to-spherical converter: squares, root pipelines,
// two CORDIC pipelines, output formatting and the output skid stage.
// Depends on c2s_pkg and c2s_cordic.
//
//  channel | dir | fields (lowest bit first)                        | bytes
//  s_*     | in  | x_coord[15:0] y_coord[15:0] z_coord[15:0]          | 6
//  m_*     | out | radius[17:0] colatitude[15:0] azimuth[15:0], pad   | 7
//
// Throughput: one item per cycle while the skid stage is empty.
// Depth: set by the 32-step square root for r_xy, one digit per stage,
// followed by the CORDIC iteration stages.
// Stalls: the whole pipeline holds while the skid stage is occupied; s_tready comes
// from a register only, so no path runs from m_tready to s_tready.
// Reset: synchronous, active low; clears only the valid bits of the pipeline, output and skid stages.
module cartesian_to_spherical #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // x_coord[15:0], y_coord[31:16], z_coord[47:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // radius[17:0], colatitude[33:18], azimuth[49:34], zero
);
    import c2s_pkg::*;

    localparam int NV = RXY_BITS + 4 + CORDIC_STAGES;
    localparam int SR = RXY_BITS;   // index of the last root step in the carry arrays

    logic en;
    logic [NV-1:0] vld_reg;

    logic signed [COORD_BITS-1:0] x_in, y_in, z_in;
    assign x_in = s_tdata[COORD_BITS-1:0];
    assign y_in = s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign z_in = s_tdata[3*COORD_BITS-1:2*COORD_BITS];

    // ---------------------------------------------------------------- squares
    logic signed [SQ_BITS-1:0] xsq_next, ysq_next, zsq_next;
    assign xsq_next = SQ_BITS'(x_in) * SQ_BITS'(x_in);
    assign ysq_next = SQ_BITS'(y_in) * SQ_BITS'(y_in);
    assign zsq_next = SQ_BITS'(z_in) * SQ_BITS'(z_in);

    logic signed [COORD_BITS-1:0] xa_reg, ya_reg, za_reg;
    logic [SQ_BITS-1:0] xsq_reg, ysq_reg, zsq_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            xa_reg  <= x_in;
            ya_reg  <= y_in;
            za_reg  <= z_in;
            xsq_reg <= xsq_next;
            ysq_reg <= ysq_next;
            zsq_reg <= zsq_next;
        end
    end

    // -------------------------------------------------------- sums, root carry
    logic signed [COORD_BITS-1:0] xp_reg [0:SR];
    logic signed [COORD_BITS-1:0] yp_reg [0:SR];
    logic signed [COORD_BITS-1:0] zp_reg [0:SR];
    logic [SQ_BITS-1:0]     sxy_reg     [0:SR];
    logic [SQ_BITS-1:0]     s3_reg      [0:SR];
    logic [XR_REM_W-1:0]    xr_rem_reg  [0:SR];
    logic [RXY_BITS-1:0]    xr_root_reg [0:SR];
    logic [RD_REM_W-1:0]    rd_rem_reg  [0:SR];
    logic [RADIUS_BITS-1:0] rd_root_reg [0:SR];

    always_ff @(posedge aclk) begin
        if (en) begin
            xp_reg[0]      <= xa_reg;
            yp_reg[0]      <= ya_reg;
            zp_reg[0]      <= za_reg;
            sxy_reg[0]     <= xsq_reg + ysq_reg;
            s3_reg[0]      <= xsq_reg + ysq_reg + zsq_reg;
            xr_rem_reg[0]  <= '0;
            xr_root_reg[0] <= '0;
            rd_rem_reg[0]  <= '0;
            rd_root_reg[0] <= '0;
        end
    end

    // One root digit per stage. r_xy is the root of sxy * 2^(2*FRAC_BITS), the radius
    // the root of (x^2+y^2+z^2) * 16; both start at their top digit in step zero.
    for (genvar k = 0; k < RXY_BITS; k++) begin : g_root
        localparam int J  = RXY_BITS - 1 - k;
        localparam int RJ = RADIUS_BITS - 1 - k;

        logic [1:0]          xr_bits;
        logic [XR_REM_W-1:0] xr_sh, xr_trial;
        logic                xr_take;
        logic [RD_REM_W-1:0] rd_rem_next;
        logic [RADIUS_BITS-1:0] rd_root_next;

        if (J >= FRAC_BITS) begin : g_xr_data
            assign xr_bits = sxy_reg[k][2*(J-FRAC_BITS)+1 -: 2];
        end else begin : g_xr_zero
            assign xr_bits = 2'b00;
        end

        assign xr_sh    = {xr_rem_reg[k][XR_REM_W-3:0], xr_bits};
        assign xr_trial = XR_REM_W'({xr_root_reg[k], 2'b01});
        assign xr_take  = xr_sh >= xr_trial;

        if (RJ >= 0) begin : g_rd_step
            logic [1:0]          rd_bits;
            logic [RD_REM_W-1:0] rd_sh, rd_trial;
            logic                rd_take;
            if (RJ >= RD_PAD) begin : g_rd_data
                assign rd_bits = s3_reg[k][2*(RJ-RD_PAD)+1 -: 2];
            end else begin : g_rd_zero
                assign rd_bits = 2'b00;
            end
            assign rd_sh        = {rd_rem_reg[k][RD_REM_W-3:0], rd_bits};
            assign rd_trial     = RD_REM_W'({rd_root_reg[k], 2'b01});
            assign rd_take      = rd_sh >= rd_trial;
            assign rd_rem_next  = rd_take ? rd_sh - rd_trial : rd_sh;
            assign rd_root_next = {rd_root_reg[k][RADIUS_BITS-2:0], rd_take};
        end else begin : g_rd_hold
            assign rd_rem_next  = rd_rem_reg[k];
            assign rd_root_next = rd_root_reg[k];
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                xp_reg[k+1]      <= xp_reg[k];
                yp_reg[k+1]      <= yp_reg[k];
                zp_reg[k+1]      <= zp_reg[k];
                sxy_reg[k+1]     <= sxy_reg[k];
                s3_reg[k+1]      <= s3_reg[k];
                xr_rem_reg[k+1]  <= xr_take ? xr_sh - xr_trial : xr_sh;
                xr_root_reg[k+1] <= {xr_root_reg[k][RXY_BITS-2:0], xr_take};
                rd_rem_reg[k+1]  <= rd_rem_next;
                rd_root_reg[k+1] <= rd_root_next;
            end
        end
    end

    // ------------------------------------------------------ rounding stage
    logic [RXY_BITS-1:0]  rxy_next;
    logic [RADIUS_BITS:0] rad_sum;
    logic [RADIUS_BITS-1:0] rad_next;

    // round to nearest: step up when the remainder exceeds the root
    assign rxy_next = xr_root_reg[SR]
        + RXY_BITS'(xr_rem_reg[SR] > XR_REM_W'(xr_root_reg[SR]));
    assign rad_sum  = {1'b0, rd_root_reg[SR]}
        + (RADIUS_BITS+1)'(rd_rem_reg[SR] > RD_REM_W'(rd_root_reg[SR]));
    assign rad_next = rad_sum[RADIUS_BITS] ? RADIUS_MAX : rad_sum[RADIUS_BITS-1:0];

    logic [RXY_BITS-1:0] rxy_reg;
    logic signed [COORD_BITS-1:0] xr_reg, yr_reg, zr_reg;
    side_t side_rnd_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            rxy_reg             <= rxy_next;
            xr_reg              <= xp_reg[SR];
            yr_reg              <= yp_reg[SR];
            zr_reg              <= zp_reg[SR];
            side_rnd_reg.radius <= rad_next;
            side_rnd_reg.axis   <= (xp_reg[SR] == '0) && (yp_reg[SR] == '0);
            side_rnd_reg.zneg   <= zp_reg[SR][COORD_BITS-1];
        end
    end

    // ------------------------------------------------------ angle pipelines
    cvec_t phi_x, phi_y, th_x, th_y;
    angle_t phi_ang, th_ang;

    assign phi_x = cvec_t'(zr_reg) <<< FRAC_BITS;
    assign phi_y = cvec_t'($signed({1'b0, rxy_reg}));
    assign th_x  = cvec_t'(xr_reg) <<< FRAC_BITS;
    assign th_y  = cvec_t'(yr_reg) <<< FRAC_BITS;

    c2s_cordic #(.STAGES(CORDIC_STAGES)) u_phi (
        .aclk   (aclk),
        .en     (en),
        .x_in   (phi_x),
        .y_in   (phi_y),
        .ang_out(phi_ang)
    );

    c2s_cordic #(.STAGES(CORDIC_STAGES)) u_theta (
        .aclk   (aclk),
        .en     (en),
        .x_in   (th_x),
        .y_in   (th_y),
        .ang_out(th_ang)
    );

    // hold radius and axis flags alongside the CORDIC stages
    side_t side_reg [0:CORDIC_STAGES];

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= side_rnd_reg;
        end
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_side
        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[i+1] <= side_reg[i];
            end
        end
    end

    // ------------------------------------------------------ output formatting
    side_t  side_last;
    angle_t phi_clamp, phi_sum, th_sum;
    logic [ANGLE_BITS-1:0] colat_next, azim_next;
    logic [55:0] data_next;

    assign side_last = side_reg[CORDIC_STAGES];

    always_comb begin
        // a CORDIC overshoot below zero lands in the upper half turn: clamp to zero
        phi_clamp = phi_ang[TURN_BITS-1] ? '0 : phi_ang;
        phi_sum   = phi_clamp + ANGLE_HALF;
        th_sum    = th_ang + ANGLE_HALF;   // a round-up to a full turn wraps to zero
        if (side_last.axis) begin
            colat_next = side_last.zneg ? PI_ANGLE : '0;
            azim_next  = '0;
        end else begin
            colat_next = phi_sum[TURN_BITS-1 -: ANGLE_BITS];
            azim_next  = th_sum[TURN_BITS-1 -: ANGLE_BITS];
        end
        data_next = '0;
        data_next[RADIUS_BITS-1:0] = side_last.radius;
        data_next[RADIUS_BITS +: ANGLE_BITS] = colat_next;
        data_next[RADIUS_BITS+ANGLE_BITS +: ANGLE_BITS] = azim_next;
    end

    // ------------------------------------------------------ valid chain, output, skid
    logic        m_tvalid_reg, skid_vld_reg;
    logic [55:0] m_tdata_reg, skid_data_reg;
    logic        last_vld;
    logic        out_free;

    assign en       = !skid_vld_reg;
    assign s_tready = en;
    assign last_vld = vld_reg[NV-1];
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else begin
            if (en) begin
                vld_reg <= {vld_reg[NV-2:0], s_tvalid};
            end
            if (out_free) begin
                m_tvalid_reg <= skid_vld_reg || (en && last_vld);
                skid_vld_reg <= 1'b0;
            end else if (en && last_vld) begin
                skid_vld_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            m_tdata_reg <= skid_vld_reg ? skid_data_reg : data_next;
        end else if (en) begin
            skid_data_reg <= data_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef NO_ASSERTIONS
    a_skid_has_output: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_vld_reg |-> m_tvalid_reg)
        else $error("skid stage full while output stage empty");

    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_vld_reg) |-> $past(m_tvalid_reg && !m_tready))
        else $error("skid stage filled without a stalled output");

    a_colat_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (m_tdata_reg[RADIUS_BITS +: ANGLE_BITS] <= PI_ANGLE))
        else $error("colatitude beyond pi");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid_reg && !skid_vld_reg && (vld_reg == '0)))
        else $error("output or pipeline valid after reset");
`endif

endmodule
